### hw/rtl/pdu_signal_pack_unpack_macros.svh
// ----------------------------------------------------------------------------
// PDU signal pack/unpack - assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PDU_SIGNAL_PACK_UNPACK_MACROS_SVH
`define PDU_SIGNAL_PACK_UNPACK_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define PSP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdu_signal_pack_unpack: same-cycle check failed");

// next-cycle implication, disabled during reset
`define PSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdu_signal_pack_unpack: next-cycle check failed");

`else

`define PSP_ASSERT_NOW(label, clk, rst, ante, cons)
`define PSP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/psp_pkg.sv
// ----------------------------------------------------------------------------
// PDU signal pack/unpack - package
// Opcodes, widths and the per-transaction plan shared by decode and datapath.
// ----------------------------------------------------------------------------
package psp_pkg;

   localparam int PDU_BYTES_DEF = 8;
   localparam int BYTE_W        = 8;
   localparam int SIG_W         = 32;
   localparam int IDX_W         = 3;
   localparam int POS_W         = IDX_W + 3;
   localparam int MAX_SPAN      = 5;                 // bytes a 32-bit field can touch
   localparam int WIN_W         = MAX_SPAN * BYTE_W; // byte-aligned field window
   localparam int SPAN_W        = 3;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_PUT_SIG  = 2'd0;
   localparam opcode_type OP_GET_SIG  = 2'd1;
   localparam opcode_type OP_WR_BYTE  = 2'd2;
   localparam opcode_type OP_RD_BYTE  = 2'd3;

   // Decoded transaction: which bytes to touch and how
   typedef struct packed {
      logic              err;       // bad position or length
      logic              wr;        // bytes are written back
      logic              get_sig;   // result carries the unpacked field
      logic              get_byte;  // result carries one raw byte
      logic [IDX_W-1:0]  start;     // first buffer byte
      logic [SPAN_W-1:0] nbytes;    // bytes touched, 1..MAX_SPAN
      logic [2:0]        sbit;      // field offset within the window
      logic [WIN_W-1:0]  win;       // write data aligned to the window
      logic [WIN_W-1:0]  mask;      // field bits within the window
   } plan_type;

endpackage

### hw/rtl/psp_field.sv
// ----------------------------------------------------------------------------
// PDU signal pack/unpack - field decode
// Checks a request's position and length and builds the byte window plan.
// ----------------------------------------------------------------------------
module psp_field #(
   parameter int PDU_BYTES = psp_pkg::PDU_BYTES_DEF
) (
   input  psp_pkg::opcode_type           opcode,
   input  logic [psp_pkg::IDX_W-1:0]     start_byte,
   input  logic [2:0]                    start_bit,
   input  logic [psp_pkg::IDX_W-1:0]     end_byte,
   input  logic [2:0]                    end_bit,
   input  logic [psp_pkg::SIG_W-1:0]     signal_value,
   input  logic [psp_pkg::BYTE_W-1:0]    byte_value,
   output psp_pkg::plan_type             plan
);

   logic [psp_pkg::POS_W-1:0] p0;
   logic [psp_pkg::POS_W-1:0] p1;
   logic [psp_pkg::POS_W-1:0] diff;
   logic [psp_pkg::POS_W-1:0] len;
   logic                      sb_out;
   logic                      eb_out;
   logic                      sig_err;

   // linear bit positions and range checks
   assign p0      = {start_byte, start_bit};
   assign p1      = {end_byte, end_bit};
   assign diff    = p1 - p0;
   assign len     = diff + psp_pkg::POS_W'(1);
   assign sb_out  = 32'(start_byte) >= PDU_BYTES;
   assign eb_out  = 32'(end_byte) >= PDU_BYTES;
   assign sig_err = sb_out || eb_out || (p1 < p0) ||
                    (32'(diff) >= psp_pkg::SIG_W);

   // plan per opcode
   always_comb begin
      plan          = '0;
      plan.start    = start_byte;
      unique case (opcode)
         psp_pkg::OP_PUT_SIG, psp_pkg::OP_GET_SIG: begin
            plan.err     = sig_err;
            plan.wr      = (opcode == psp_pkg::OP_PUT_SIG) && !sig_err;
            plan.get_sig = (opcode == psp_pkg::OP_GET_SIG) && !sig_err;
            plan.nbytes  = psp_pkg::SPAN_W'(end_byte - start_byte) + psp_pkg::SPAN_W'(1);
            plan.sbit    = start_bit;
            plan.win     = psp_pkg::WIN_W'(signal_value) << start_bit;
            plan.mask    = ((psp_pkg::WIN_W'(1) << len) - psp_pkg::WIN_W'(1)) << start_bit;
         end
         psp_pkg::OP_WR_BYTE, psp_pkg::OP_RD_BYTE: begin
            plan.err      = sb_out;
            plan.wr       = (opcode == psp_pkg::OP_WR_BYTE) && !sb_out;
            plan.get_byte = (opcode == psp_pkg::OP_RD_BYTE) && !sb_out;
            plan.nbytes   = psp_pkg::SPAN_W'(1);
            plan.win      = psp_pkg::WIN_W'(byte_value);
            plan.mask     = psp_pkg::WIN_W'({psp_pkg::BYTE_W{1'b1}});
         end
         default: plan = '0;
      endcase
   end

endmodule

### hw/rtl/pdu_signal_pack_unpack.sv
// ----------------------------------------------------------------------------
// PDU signal pack/unpack
// Byte buffer with bit-field put/get and raw byte load/unload.
//
//   channel  | ports                      | direction
//   ---------+----------------------------+----------
//   request  | req_valid/req_ready, req_* | in
//   response | rsp_valid/rsp_ready, rsp_* | out
//
// One transaction at a time. A field touching n bytes (1..5) makes n reads of
// the byte-wide buffer, one read per cycle, each byte merged and written back
// in the cycle its read data returns. Invalid requests skip the reads and
// respond with nothing touched.
// Synchronous reset clears the per-byte valid bits; unwritten bytes read zero.
// A stalled response admits one more request, which then waits and holds input off.
// ----------------------------------------------------------------------------
`include "pdu_signal_pack_unpack_macros.svh"

module pdu_signal_pack_unpack #(
   parameter int PDU_BYTES = psp_pkg::PDU_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [psp_pkg::IDX_W-1:0]     req_start_byte,
   input  logic [2:0]                    req_start_bit,
   input  logic [psp_pkg::IDX_W-1:0]     req_end_byte,
   input  logic [2:0]                    req_end_bit,
   input  logic [psp_pkg::SIG_W-1:0]     req_signal_value,
   input  logic [psp_pkg::BYTE_W-1:0]    req_byte_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [psp_pkg::SIG_W-1:0]     rsp_signal_out,
   output logic [psp_pkg::BYTE_W-1:0]    rsp_byte_out,
   output logic                          rsp_status
);

   localparam int AW = (PDU_BYTES > 1) ? $clog2(PDU_BYTES) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   psp_pkg::plan_type plan_dec;
   psp_pkg::plan_type plan_ff;

   logic [1:0]                  state_ff, state_in;
   logic [psp_pkg::SPAN_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic                        rd_pend_ff;
   logic [psp_pkg::SPAN_W-1:0]  rd_rel_ff;
   logic [psp_pkg::WIN_W-1:0]   acc_ff;
   logic                        rsp_valid_ff;
   logic [psp_pkg::SIG_W-1:0]   rsp_sig_ff;
   logic [psp_pkg::BYTE_W-1:0]  rsp_byte_ff;
   logic                        rsp_status_ff;

   logic [psp_pkg::BYTE_W-1:0]  mem [PDU_BYTES];
   logic [PDU_BYTES-1:0]        vld_ff;
   logic [psp_pkg::BYTE_W-1:0]  mem_q_ff;
   logic                        vld_q_ff;

   logic                        req_fire;
   logic                        rd_issue;
   logic [AW-1:0]               rd_addr;
   logic [AW-1:0]               wr_addr;
   logic                        mem_we;
   logic [psp_pkg::BYTE_W-1:0]  old_byte;
   logic [psp_pkg::BYTE_W-1:0]  mask_byte;
   logic [psp_pkg::BYTE_W-1:0]  win_byte;
   logic [psp_pkg::BYTE_W-1:0]  new_byte;
   logic [5:0]                  lane;
   logic                        last_byte;
   logic                        out_free;

   // request decode
   psp_field #(
      .PDU_BYTES (PDU_BYTES)
   ) u_field (
      .opcode       (req_opcode),
      .start_byte   (req_start_byte),
      .start_bit    (req_start_bit),
      .end_byte     (req_end_byte),
      .end_bit      (req_end_bit),
      .signal_value (req_signal_value),
      .byte_value   (req_byte_value),
      .plan         (plan_dec)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // read issue and byte merge
   assign rd_issue  = (state_ff == S_RUN) && (rd_cnt_ff != plan_ff.nbytes);
   assign rd_addr   = AW'(plan_ff.start + psp_pkg::IDX_W'(rd_cnt_ff));
   assign wr_addr   = AW'(plan_ff.start + psp_pkg::IDX_W'(rd_rel_ff));
   assign lane      = {rd_rel_ff, 3'b000};
   assign old_byte  = vld_q_ff ? mem_q_ff : '0;
   assign mask_byte = plan_ff.mask[lane +: psp_pkg::BYTE_W];
   assign win_byte  = plan_ff.win[lane +: psp_pkg::BYTE_W];
   assign new_byte  = (old_byte & ~mask_byte) | (win_byte & mask_byte);
   assign mem_we    = rd_pend_ff && plan_ff.wr;
   assign last_byte = rd_pend_ff && (rd_rel_ff == plan_ff.nbytes - psp_pkg::SPAN_W'(1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // buffer memory, one read and one write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= new_byte;
      end
      if (rd_issue) begin
         mem_q_ff <= mem[rd_addr];
         vld_q_ff <= vld_ff[rd_addr];
      end
   end

   // per-byte written flags
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      rd_cnt_in = rd_cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            rd_cnt_in = '0;
            if (req_fire) begin
               state_in = plan_dec.err ? S_DONE : S_RUN;
            end
         end
         S_RUN: begin
            if (rd_issue) begin
               rd_cnt_in = rd_cnt_ff + psp_pkg::SPAN_W'(1);
            end
            if (last_byte) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rd_cnt_ff  <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_cnt_ff  <= rd_cnt_in;
         rd_pend_ff <= rd_issue;
      end
   end

   // transaction plan, read tag and gathered bytes
   always_ff @(posedge clock) begin
      if (req_fire) begin
         plan_ff <= plan_dec;
         acc_ff  <= '0;
      end else if (rd_pend_ff) begin
         acc_ff[lane +: psp_pkg::BYTE_W] <= old_byte & mask_byte;
      end
      if (rd_issue) begin
         rd_rel_ff <= rd_cnt_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && out_free) begin
         rsp_sig_ff    <= plan_ff.get_sig ?
                          psp_pkg::SIG_W'(acc_ff >> plan_ff.sbit) : '0;
         rsp_byte_ff   <= plan_ff.get_byte ? acc_ff[psp_pkg::BYTE_W-1:0] : '0;
         rsp_status_ff <= plan_ff.err;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_signal_out = rsp_sig_ff;
   assign rsp_byte_out   = rsp_byte_ff;
   assign rsp_status     = rsp_status_ff;

   // checks
   `PSP_ASSERT_NOW(a_we_in_run, clock, reset, mem_we, state_ff == S_RUN)
   `PSP_ASSERT_NOW(a_rd_cnt_bound, clock, reset, state_ff == S_RUN, rd_cnt_ff <= plan_ff.nbytes)
   `PSP_ASSERT_NOW(a_err_no_touch, clock, reset, state_ff == S_RUN, !plan_ff.err)
   `PSP_ASSERT_NEXT(a_err_to_done, clock, reset, req_fire && plan_dec.err, state_ff == S_DONE)

endmodule

### tb/pdu_signal_pack_unpack_tb.sv
// ----------------------------------------------------------------------------
// PDU signal pack/unpack - testbench
// Sends field puts and gets, raw byte loads and unloads, and bad positions
// through the request channel. Each response is checked against a local copy
// of the byte buffer. Both channels idle at random, with one long response
// hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module pdu_signal_pack_unpack_tb;
   import psp_pkg::*;

   localparam int RANDOM_ITEMS = 630;
   localparam int CALM_TAIL    = 80;   // final transactions run with no idling
   localparam int HOLD_AT      = 200;  // long response hold-off starts here
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_POS      = PDU_BYTES_DEF * 8 - 1;

   typedef struct packed {
      opcode_type        opcode;
      logic [IDX_W-1:0]  start_byte;
      logic [2:0]        start_bit;
      logic [IDX_W-1:0]  end_byte;
      logic [2:0]        end_bit;
      logic [SIG_W-1:0]  signal_value;
      logic [BYTE_W-1:0] byte_value;
   } req_item_type;

   typedef struct packed {
      logic [SIG_W-1:0]  signal_out;
      logic [BYTE_W-1:0] byte_out;
      logic              status;
   } rsp_item_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [1:0]        req_opcode       = '0;
   logic [IDX_W-1:0]  req_start_byte   = '0;
   logic [2:0]        req_start_bit    = '0;
   logic [IDX_W-1:0]  req_end_byte     = '0;
   logic [2:0]        req_end_bit      = '0;
   logic [SIG_W-1:0]  req_signal_value = '0;
   logic [BYTE_W-1:0] req_byte_value   = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic [SIG_W-1:0]  rsp_signal_out;
   logic [BYTE_W-1:0] rsp_byte_out;
   logic              rsp_status;

   pdu_signal_pack_unpack dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_start_byte  (req_start_byte),
      .req_start_bit   (req_start_bit),
      .req_end_byte    (req_end_byte),
      .req_end_bit     (req_end_bit),
      .req_signal_value(req_signal_value),
      .req_byte_value  (req_byte_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_signal_out  (rsp_signal_out),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_status      (rsp_status)
   );

   always #5 clock = ~clock;

   // Local image of the PDU buffer and test bookkeeping
   logic [BYTE_W-1:0] pdu_image [PDU_BYTES_DEF];
   req_item_type      pending_reqs [$];
   rsp_item_type      expected_rsps [$];
   int                put_lo [$];
   int                put_hi [$];
   int                total_items;
   int                calm_from;
   int                accepted_count = 0;
   int                error_count    = 0;
   int                rsp_count      = 0;
   int                rejected_count = 0;
   int                op_count [4]   = '{0, 0, 0, 0};

   // Apply one transaction to the buffer image and give its response
   function automatic rsp_item_type apply_pdu_access(input req_item_type it);
      rsp_item_type r;
      int lo_pos;
      int hi_pos;
      int pos;
      r = '0;
      lo_pos = int'(it.start_byte) * 8 + int'(it.start_bit);
      hi_pos = int'(it.end_byte) * 8 + int'(it.end_bit);
      if (it.opcode == OP_PUT_SIG || it.opcode == OP_GET_SIG) begin
         if (int'(it.start_byte) >= PDU_BYTES_DEF || int'(it.end_byte) >= PDU_BYTES_DEF ||
             hi_pos < lo_pos || hi_pos - lo_pos + 1 > SIG_W) begin
            r.status = 1'b1;
         end else begin
            for (int k = 0; k <= hi_pos - lo_pos; k++) begin
               pos = lo_pos + k;
               if (it.opcode == OP_PUT_SIG)
                  pdu_image[pos >> 3][pos & 7] = it.signal_value[k];
               else
                  r.signal_out[k] = pdu_image[pos >> 3][pos & 7];
            end
         end
      end else if (int'(it.start_byte) >= PDU_BYTES_DEF) begin
         r.status = 1'b1;
      end else if (it.opcode == OP_WR_BYTE) begin
         pdu_image[it.start_byte] = it.byte_value;
      end else begin
         r.byte_out = pdu_image[it.start_byte];
      end
      return r;
   endfunction

   // Set start and end from linear bit positions
   function automatic req_item_type place_field(input req_item_type it, input int lo_pos,
                                                input int hi_pos);
      it.start_byte = lo_pos[5:3];
      it.start_bit  = lo_pos[2:0];
      it.end_byte   = hi_pos[5:3];
      it.end_bit    = hi_pos[2:0];
      return it;
   endfunction

   function automatic int random_hi(input int lo_pos);
      int room;
      room = (MAX_POS - lo_pos < SIG_W - 1) ? MAX_POS - lo_pos : SIG_W - 1;
      return lo_pos + $urandom_range(0, room);
   endfunction

   // Random transaction: mostly well-formed puts and gets, gets often
   // reading back a recent put; unused fields stay random
   function automatic req_item_type random_pdu_access();
      req_item_type it;
      int pick;
      int lo_pos;
      int hi_pos;
      int slot;
      it.opcode       = opcode_type'($urandom_range(0, 3));
      it.start_byte   = IDX_W'($urandom_range(0, 7));
      it.start_bit    = 3'($urandom_range(0, 7));
      it.end_byte     = IDX_W'($urandom_range(0, 7));
      it.end_bit      = 3'($urandom_range(0, 7));
      it.signal_value = $urandom();
      it.byte_value   = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         it.opcode = OP_PUT_SIG;
         lo_pos = $urandom_range(0, MAX_POS);
         hi_pos = random_hi(lo_pos);
         it = place_field(it, lo_pos, hi_pos);
         put_lo.push_back(lo_pos);
         put_hi.push_back(hi_pos);
         if (put_lo.size() > 8) begin
            void'(put_lo.pop_front());
            void'(put_hi.pop_front());
         end
      end else if (pick < 75) begin
         it.opcode = OP_GET_SIG;
         if (put_lo.size() != 0 && $urandom_range(0, 1) == 1) begin
            slot = $urandom_range(0, put_lo.size() - 1);
            it = place_field(it, put_lo[slot], put_hi[slot]);
         end else begin
            lo_pos = $urandom_range(0, MAX_POS);
            it = place_field(it, lo_pos, random_hi(lo_pos));
         end
      end else if (pick < 85) begin
         it.opcode = OP_WR_BYTE;
      end else if (pick < 93) begin
         it.opcode = OP_RD_BYTE;
      end else begin
         // bad field: end before start, or longer than a signal
         it.opcode = $urandom_range(0, 1) ? OP_PUT_SIG : OP_GET_SIG;
         if ($urandom_range(0, 1) == 1) begin
            lo_pos = $urandom_range(1, MAX_POS);
            hi_pos = $urandom_range(0, lo_pos - 1);
         end else begin
            lo_pos = $urandom_range(0, MAX_POS - SIG_W);
            hi_pos = $urandom_range(lo_pos + SIG_W, MAX_POS);
         end
         it = place_field(it, lo_pos, hi_pos);
      end
      return it;
   endfunction

   // Directed transaction; byte opcodes take the byte of lo_pos
   task automatic queue_access(input opcode_type op, input int lo_pos, input int hi_pos,
                               input logic [SIG_W-1:0] sig, input logic [BYTE_W-1:0] bval);
      req_item_type it;
      it = '0;
      it.opcode       = op;
      it.signal_value = sig;
      it.byte_value   = bval;
      pending_reqs.push_back(place_field(it, lo_pos, hi_pos));
   endtask

   task automatic check_field(input string name, input logic [SIG_W-1:0] want,
                              input logic [SIG_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Request driver: holds each transaction until accepted, idles in bursts
   int           send_gap = 0;
   req_item_type next_req;
   req_item_type taken_req;
   rsp_item_type predicted_rsp;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            taken_req.opcode       = req_opcode;
            taken_req.start_byte   = req_start_byte;
            taken_req.start_bit    = req_start_bit;
            taken_req.end_byte     = req_end_byte;
            taken_req.end_bit      = req_end_bit;
            taken_req.signal_value = req_signal_value;
            taken_req.byte_value   = req_byte_value;
            predicted_rsp = apply_pdu_access(taken_req);
            expected_rsps.push_back(predicted_rsp);
            op_count[taken_req.opcode]++;
            if (predicted_rsp.status)
               rejected_count++;
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (accepted_count < calm_from && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 14);
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               next_req = pending_reqs.pop_front();
               req_opcode       <= next_req.opcode;
               req_start_byte   <= next_req.start_byte;
               req_start_bit    <= next_req.start_bit;
               req_end_byte     <= next_req.end_byte;
               req_end_bit      <= next_req.end_bit;
               req_signal_value <= next_req.signal_value;
               req_byte_value   <= next_req.byte_value;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response receiver: random stall bursts plus one long hold-off
   int stall_left = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (accepted_count < calm_from && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Response monitor: compare against the oldest expectation
   rsp_item_type due_rsp;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h/%h/%b", $time,
                     rsp_signal_out, rsp_byte_out, rsp_status);
            error_count++;
         end else begin
            due_rsp = expected_rsps.pop_front();
            check_field("signal_out", due_rsp.signal_out, rsp_signal_out);
            check_field("byte_out", SIG_W'(due_rsp.byte_out), SIG_W'(rsp_byte_out));
            check_field("status", SIG_W'(due_rsp.status), SIG_W'(rsp_status));
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      foreach (pdu_image[i])
         pdu_image[i] = '0;

      // whole-field extremes, five-byte spans, single bits, neighbors kept
      queue_access(OP_GET_SIG, 0, 31, 32'h0, 8'h00);
      queue_access(OP_PUT_SIG, 0, 31, 32'hFFFF_FFFF, 8'hFF);
      queue_access(OP_GET_SIG, 0, 31, 32'h0, 8'h00);
      queue_access(OP_PUT_SIG, 28, 59, 32'hA5A5_A5A5, 8'h00);
      queue_access(OP_GET_SIG, 28, 59, 32'h0, 8'h00);
      queue_access(OP_PUT_SIG, 63, 63, 32'hFFFF_FFFF, 8'h00);
      queue_access(OP_GET_SIG, 63, 63, 32'h0, 8'h00);
      queue_access(OP_PUT_SIG, 19, 21, 32'hFFFF_FFF2, 8'h00);
      queue_access(OP_GET_SIG, 16, 23, 32'h0, 8'h00);
      queue_access(OP_RD_BYTE, 16, 16, 32'h0, 8'h00);
      queue_access(OP_WR_BYTE, 0, 0, 32'hFFFF_FFFF, 8'h00);
      queue_access(OP_WR_BYTE, 56, 56, 32'h0, 8'hFF);
      queue_access(OP_RD_BYTE, 0, 0, 32'h0, 8'hFF);
      queue_access(OP_RD_BYTE, 56, 56, 32'h0, 8'h00);
      queue_access(OP_GET_SIG, 0, 0, 32'h0, 8'h00);
      // end before start, and fields longer than 32 bits
      queue_access(OP_PUT_SIG, 43, 42, 32'hFFFF_FFFF, 8'h00);
      queue_access(OP_GET_SIG, 32, 31, 32'h0, 8'h00);
      queue_access(OP_GET_SIG, 0, 32, 32'h0, 8'h00);
      queue_access(OP_PUT_SIG, 9, 41, 32'h0, 8'h00);
      queue_access(OP_PUT_SIG, 0, 63, 32'h0, 8'h00);
      // nothing changed by the rejected puts
      queue_access(OP_GET_SIG, 28, 59, 32'h0, 8'h00);
      queue_access(OP_GET_SIG, 8, 39, 32'h0, 8'h00);

      for (int i = 0; i < RANDOM_ITEMS; i++)
         pending_reqs.push_back(random_pdu_access());

      total_items = pending_reqs.size();
      calm_from   = total_items - CALM_TAIL;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d transactions: %0d puts, %0d gets, %0d byte writes, %0d byte reads",
               total_items, op_count[OP_PUT_SIG], op_count[OP_GET_SIG],
               op_count[OP_WR_BYTE], op_count[OP_RD_BYTE]);
      $display("%0d responses checked, %0d bad fields rejected, %0d errors",
               rsp_count, rejected_count, error_count);
      if (error_count == 0)
         $display("pdu_signal_pack_unpack regression: pass");
      else
         $display("pdu_signal_pack_unpack regression: fail");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Timeout with %0d of %0d transactions accepted", accepted_count, total_items);
      $display("pdu_signal_pack_unpack regression: fail");
      $finish;
   end

endmodule
